// ----- src/jgsd_pkg.sv -----
// Shared constants, types and the gain reciprocal table of the joint goal smoother.
`timescale 1ns / 1ps
`default_nettype none

package jgsd_pkg;

  // Joint array and position range
  localparam int NUM_JOINTS    = 18;
  localparam int POSITION_BITS = 12;
  localparam int POS_MAX       = (1 << POSITION_BITS) - 1;
  localparam int JIDX_W        = $clog2(NUM_JOINTS);

  // Fixed field widths of the channels and registers
  localparam int TIME_W     = 32;
  localparam int JOINT_W    = 5;
  localparam int GOAL_W     = 12;
  localparam int INTERVAL_W = 16;
  localparam int GAIN_W     = 4;
  localparam int DEADBAND_W = 12;
  localparam int MASK_BITS  = 18;
  localparam int CMP_W      = 16;

  // Smoothing gain is num / GAIN_DEN, applied as a multiply by a scaled reciprocal
  localparam int GAIN_DEN    = 10;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = POSITION_BITS + RECIP_W;

  // Queue between front and back
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(20);
  localparam logic [GAIN_W-1:0]     GAIN_RESET     = GAIN_W'(3);
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = DEADBAND_W'(1);
  localparam logic [MASK_BITS-1:0]  MASK_RESET     = {MASK_BITS{1'b1}};

  typedef enum logic [1:0] {
    REG_SEND_INTERVAL = 2'd0,
    REG_SMOOTH_GAIN   = 2'd1,
    REG_SEND_DEADBAND = 2'd2,
    REG_JOINT_MASK    = 2'd3
  } reg_idx_t;

  typedef logic [TIME_W-1:0]        ms_t;
  typedef logic [JOINT_W-1:0]       joint_t;
  typedef logic [GOAL_W-1:0]        goal_t;
  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] send_interval_ms;
    logic [GAIN_W-1:0]     smooth_gain_num;
    logic [DEADBAND_W-1:0] send_deadband;
    logic [MASK_BITS-1:0]  joint_enable_mask;
  } cfg_t;

  // One classified goal beat as it waits in the queue.
  typedef struct packed {
    ms_t    now_ms;
    logic   first;
    logic   last;
    logic   eligible;
    joint_t joint;
    pos_t   goal;
  } item_t;

  // ceil(num * 2^RECIP_SHIFT / 10); gains above ten saturate to ten.
  function automatic logic [RECIP_W-1:0] gain_recip(input logic [GAIN_W-1:0] num);
    logic [RECIP_W-1:0] r;
    case (num)
      4'd0:    r = 21'd0;
      4'd1:    r = 21'd104858;
      4'd2:    r = 21'd209716;
      4'd3:    r = 21'd314573;
      4'd4:    r = 21'd419431;
      4'd5:    r = 21'd524288;
      4'd6:    r = 21'd629146;
      4'd7:    r = 21'd734004;
      4'd8:    r = 21'd838861;
      4'd9:    r = 21'd943719;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/jgsd_if.sv -----
// Valid/ready channel interfaces for goal beats in and send beats out.
`timescale 1ns / 1ps
`default_nettype none

interface jgsd_in_if;
  import jgsd_pkg::*;
  logic   valid;
  logic   ready;
  ms_t    now_ms;
  logic   first_of_frame;
  logic   last_of_frame;
  logic   joint_mapped;
  joint_t joint_index;
  goal_t  goal_position;

  modport source (output valid, now_ms, first_of_frame, last_of_frame, joint_mapped,
                  joint_index, goal_position, input ready);
  modport sink (input valid, now_ms, first_of_frame, last_of_frame, joint_mapped,
                joint_index, goal_position, output ready);
endinterface

interface jgsd_out_if;
  import jgsd_pkg::*;
  logic   valid;
  logic   ready;
  logic   send_now;
  joint_t send_joint;
  goal_t  send_position;
  logic   frame_commit;

  modport source (output valid, send_now, send_joint, send_position, frame_commit,
                  input ready);
  modport sink (input valid, send_now, send_joint, send_position, frame_commit,
                output ready);
endinterface

`default_nettype wire

// ----- src/joint_goal_smoother_deadband_top.sv -----
// Top level of the joint goal smoother: configuration registers, front, queue and back.
`timescale 1ns / 1ps
`default_nettype none

// Goal beats carry one joint each, grouped in frames by first/last flags; every goal
// beat yields exactly one send beat, in order. The block takes one goal beat per
// clock while the queue is not full, and a send beat is presented once its goal beat
// has passed through the queue and the step stage, which loads the output register.
// Two beats in a row for the same joint are held apart, because the second beat
// reads the smoothed position only after the first has written it back; a four-entry
// queue absorbs this and any stall on the send side. Registers sit at byte addresses
// 0x0 (send interval), 0x4 (smoothing gain), 0x8 (deadband) and 0xC (joint enable
// mask); they must be written only while the block is idle, and the block itself
// does not enforce this.
module joint_goal_smoother_deadband_top (
  input  logic                            clk,
  input  logic                            rst,
  jgsd_in_if.sink                         goal_ch,
  jgsd_out_if.source                      send_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jgsd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jgsd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jgsd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import jgsd_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.send_interval_ms  <= INTERVAL_RESET;
      cfg.smooth_gain_num   <= GAIN_RESET;
      cfg.send_deadband     <= DEADBAND_RESET;
      cfg.joint_enable_mask <= MASK_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_SEND_INTERVAL: cfg.send_interval_ms  <= pwdata[INTERVAL_W-1:0];
        REG_SMOOTH_GAIN:   cfg.smooth_gain_num   <= pwdata[GAIN_W-1:0];
        REG_SEND_DEADBAND: cfg.send_deadband     <= pwdata[DEADBAND_W-1:0];
        REG_JOINT_MASK:    cfg.joint_enable_mask <= pwdata[MASK_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SEND_INTERVAL: prdata = CFG_DATA_W'(cfg.send_interval_ms);
      REG_SMOOTH_GAIN:   prdata = CFG_DATA_W'(cfg.smooth_gain_num);
      REG_SEND_DEADBAND: prdata = CFG_DATA_W'(cfg.send_deadband);
      REG_JOINT_MASK:    prdata = CFG_DATA_W'(cfg.joint_enable_mask);
    endcase
  end

  logic  push;
  item_t push_item;
  logic  fifo_full;
  logic  fifo_empty;
  logic  pop;
  item_t head;

  jgsd_front u_front (
    .cfg       (cfg),
    .goal_ch   (goal_ch),
    .fifo_full (fifo_full),
    .push      (push),
    .push_item (push_item)
  );

  jgsd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (pop),
    .empty     (fifo_empty),
    .head      (head)
  );

  jgsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fifo_empty (fifo_empty),
    .head       (head),
    .pop        (pop),
    .send_ch    (send_ch)
  );

endmodule

`default_nettype wire

// ----- src/jgsd_fifo.sv -----
// Short queue of classified goal beats between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module jgsd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jgsd_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output jgsd_pkg::item_t head
);
  import jgsd_pkg::*;

  item_t                 slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   count;

  assign full  = (count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (FIFO_PTR_W + 1)'(1);
        2'b01:   count <= count - (FIFO_PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/jgsd_front.sv -----
// Front end: takes goal beats, saturates the goal and decides whether the joint takes part.
`timescale 1ns / 1ps
`default_nettype none

module jgsd_front (
  input  jgsd_pkg::cfg_t  cfg,
  jgsd_in_if.sink         goal_ch,
  input  logic            fifo_full,
  output logic            push,
  output jgsd_pkg::item_t push_item
);
  import jgsd_pkg::*;

  // Joints beyond the mask width have no enable bit and count as enabled.
  logic [(1 << JOINT_W)-1:0] enable_ext;
  logic                      in_range;
  pos_t                      goal_sat;

  assign enable_ext = {{((1 << JOINT_W) - MASK_BITS){1'b1}}, cfg.joint_enable_mask};
  assign in_range   = (32'(goal_ch.joint_index) < NUM_JOINTS);

  always_comb begin
    if (32'(goal_ch.goal_position) > POS_MAX) begin
      goal_sat = POSITION_BITS'(POS_MAX);
    end else begin
      goal_sat = POSITION_BITS'(goal_ch.goal_position);
    end
  end

  assign goal_ch.ready = !fifo_full;
  assign push          = goal_ch.valid && !fifo_full;

  always_comb begin
    push_item.now_ms   = goal_ch.now_ms;
    push_item.first    = goal_ch.first_of_frame;
    push_item.last     = goal_ch.last_of_frame;
    push_item.eligible = goal_ch.joint_mapped && in_range &&
                         enable_ext[goal_ch.joint_index];
    push_item.joint    = goal_ch.joint_index;
    push_item.goal     = goal_sat;
  end

endmodule

`default_nettype wire

// ----- src/jgsd_back.sv -----
// Back end: per-joint smoothing, deadband decision, frame gate and the output register.
`timescale 1ns / 1ps
`default_nettype none

module jgsd_back (
  input  logic            clk,
  input  logic            rst,
  input  jgsd_pkg::cfg_t  cfg,
  input  logic            fifo_empty,
  input  jgsd_pkg::item_t head,
  output logic            pop,
  jgsd_out_if.source      send_ch
);
  import jgsd_pkg::*;

  // Per-joint state
  pos_t                  smoothed_pos [NUM_JOINTS];
  logic [NUM_JOINTS-1:0] smoothed_valid;
  pos_t                  last_sent_pos [NUM_JOINTS];
  logic [NUM_JOINTS-1:0] last_sent_valid;

  // Frame state
  ms_t  last_commit_ms;
  logic frame_open;
  logic frame_any_sent;

  // Step stage: current position and scaled step magnitude of one beat
  logic  a_valid;
  item_t a_item;
  pos_t  a_cur;
  logic  a_seeded;
  logic  a_up;
  logic  a_down;
  pos_t  a_q;

  // Load side
  logic [JIDX_W-1:0]  rd_idx;
  pos_t               cur;
  pos_t               mag;
  logic [PROD_W-1:0]  prod;
  logic               hazard;
  logic               a_move;
  logic               a_load;

  assign rd_idx = head.eligible ? head.joint[JIDX_W-1:0] : '0;
  assign cur    = smoothed_pos[rd_idx];
  assign mag    = (head.goal > cur) ? (head.goal - cur) : (cur - head.goal);
  assign prod   = PROD_W'(mag) * PROD_W'(gain_recip(cfg.smooth_gain_num));

  // A beat for the joint still held in the step stage waits until that beat has
  // written its state back.
  assign hazard = a_valid && (a_item.joint == head.joint);
  assign a_move = a_valid && (!send_ch.valid || send_ch.ready);
  assign a_load = !fifo_empty && (!a_valid || a_move) && !hazard;
  assign pop    = a_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_item   <= head;
      a_cur    <= cur;
      a_seeded <= smoothed_valid[rd_idx];
      a_up     <= head.goal > cur;
      a_down   <= head.goal < cur;
      a_q      <= prod[RECIP_SHIFT +: POSITION_BITS];
    end
  end

  // Commit side
  logic [JIDX_W-1:0] wr_idx;
  logic              gate;
  logic              open_eff;
  logic              any_base;
  logic              upd;
  pos_t              step;
  pos_t              next_pos;
  pos_t              sent_ref;
  pos_t              delta;
  logic              send;
  logic              any_eff;
  logic              commit;

  assign wr_idx   = a_item.eligible ? a_item.joint[JIDX_W-1:0] : '0;
  assign gate     = (a_item.now_ms - last_commit_ms) >= TIME_W'(cfg.send_interval_ms);
  assign open_eff = a_item.first ? gate : frame_open;
  assign any_base = a_item.first ? 1'b0 : frame_any_sent;
  assign upd      = open_eff && a_item.eligible;

  // The step is at least one tick toward the goal; it never passes the goal, so
  // the result stays in range.
  assign step = (a_q == '0) ? POSITION_BITS'(1) : a_q;

  always_comb begin
    if (!a_seeded) begin
      next_pos = a_item.goal;
    end else if (a_up) begin
      next_pos = a_cur + step;
    end else if (a_down) begin
      next_pos = a_cur - step;
    end else begin
      next_pos = a_cur;
    end
  end

  assign sent_ref = last_sent_pos[wr_idx];
  assign delta    = (next_pos > sent_ref) ? (next_pos - sent_ref) : (sent_ref - next_pos);
  assign send     = upd && (!last_sent_valid[wr_idx] ||
                            (CMP_W'(delta) >= CMP_W'(cfg.send_deadband)));
  assign any_eff  = any_base || send;
  assign commit   = a_item.last && open_eff && any_eff;

  always_ff @(posedge clk) begin
    if (a_move && upd) begin
      smoothed_pos[wr_idx] <= next_pos;
    end
    if (a_move && send) begin
      last_sent_pos[wr_idx] <= next_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_valid  <= '0;
      last_sent_valid <= '0;
      last_commit_ms  <= '0;
      frame_open      <= 1'b0;
      frame_any_sent  <= 1'b0;
    end else if (a_move) begin
      if (upd) begin
        smoothed_valid[wr_idx] <= 1'b1;
      end
      if (send) begin
        last_sent_valid[wr_idx] <= 1'b1;
      end
      if (commit) begin
        last_commit_ms <= a_item.now_ms;
      end
      frame_open     <= a_item.last ? 1'b0 : open_eff;
      frame_any_sent <= a_item.last ? 1'b0 : any_eff;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      send_ch.valid <= 1'b0;
    end else if (a_move) begin
      send_ch.valid <= 1'b1;
    end else if (send_ch.ready) begin
      send_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      send_ch.send_now      <= send;
      send_ch.send_joint    <= send ? a_item.joint : '0;
      send_ch.send_position <= send ? GOAL_W'(next_pos) : '0;
      send_ch.frame_commit  <= commit;
    end
  end

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    send_ch.valid && !send_ch.send_now |->
      (send_ch.send_joint == '0) && (send_ch.send_position == '0))
    else $error("send fields not cleared on a beat without a send");

  a_frame_closes: assert property (@(posedge clk) disable iff (rst)
    a_move && a_item.last |=> !frame_open && !frame_any_sent)
    else $error("frame still open after its last beat");

  a_commit_time: assert property (@(posedge clk) disable iff (rst)
    a_move && commit |=> last_commit_ms == $past(a_item.now_ms))
    else $error("commit did not store the frame time");

  a_step_holds: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_move |=> a_valid && $stable(a_item))
    else $error("step stage changed while stalled");

endmodule

`default_nettype wire
